FILE: rtl/core/bpmb_pkg.sv
// ----------------------------------------------------------------------------
// bpmb_pkg
// Item types, register indexes and operation codes of the Boris pusher.
// ----------------------------------------------------------------------------
package bpmb_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } bpmb_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
  } bpmb_out_t;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [2:0] REG_DT    = 3'd0;
  localparam logic [2:0] REG_CHG   = 3'd1;
  localparam logic [2:0] REG_MASS  = 3'd2;
  localparam logic [2:0] REG_EX    = 3'd3;
  localparam logic [2:0] REG_EY    = 3'd4;
  localparam logic [2:0] REG_EZ    = 3'd5;
  localparam logic [2:0] REG_B0    = 3'd6;
  localparam logic [2:0] REG_GRAD  = 3'd7;

  // operand slots of the micro-program: the first 32 are stored values,
  // the rest map onto config registers and constants
  typedef enum logic [5:0] {
    R_PX, R_PY, R_PZ, R_VX, R_VY, R_VZ,
    R_QM, R_K, R_Z2, R_AB, R_T0, R_T1, R_BX, R_BY, R_BZ,
    R_DEX, R_DEY, R_DEZ, R_VMX, R_VMY, R_VMZ, R_TX, R_TY, R_TZ,
    R_TSQ, R_F, R_SX, R_SY, R_SZ, R_VPX, R_VPY, R_VPZ,
    R_DT, R_CHG, R_EX, R_EY, R_EZ, R_B0, R_GRAD, R_ONE, R_ZERO
  } reg_e;

  // one micro-op: dst = a OP b
  typedef enum logic [2:0] {
    U_MUL, U_MULH, U_ADD, U_SUB, U_NEGMUL, U_QDIV, U_FDIV
  } uop_e;

  typedef struct packed {
    uop_e op;
    reg_e dst;
    reg_e a;
    reg_e b;
  } uinst_t;

  function automatic uinst_t prog(input logic [6:0] pc);
    uinst_t u;
    u = '{U_ADD, R_ZERO, R_ZERO, R_ZERO};
    case (pc)
      7'd0:  u = '{U_QDIV, R_QM, R_CHG, R_ZERO};
      7'd1:  u = '{U_MULH, R_K, R_QM, R_DT};
      7'd2:  u = '{U_MUL, R_Z2, R_PZ, R_PZ};
      7'd3:  u = '{U_MUL, R_AB, R_GRAD, R_B0};
      7'd4:  u = '{U_MUL, R_T0, R_GRAD, R_Z2};
      7'd5:  u = '{U_ADD, R_T0, R_ONE, R_T0};
      7'd6:  u = '{U_MUL, R_BZ, R_B0, R_T0};
      7'd7:  u = '{U_MUL, R_T0, R_AB, R_PX};
      7'd8:  u = '{U_NEGMUL, R_BX, R_T0, R_PZ};
      7'd9:  u = '{U_MUL, R_T0, R_AB, R_PY};
      7'd10: u = '{U_NEGMUL, R_BY, R_T0, R_PZ};
      7'd11: u = '{U_MUL, R_DEX, R_EX, R_K};
      7'd12: u = '{U_ADD, R_VMX, R_VX, R_DEX};
      7'd13: u = '{U_MUL, R_TX, R_BX, R_K};
      7'd14: u = '{U_MUL, R_DEY, R_EY, R_K};
      7'd15: u = '{U_ADD, R_VMY, R_VY, R_DEY};
      7'd16: u = '{U_MUL, R_TY, R_BY, R_K};
      7'd17: u = '{U_MUL, R_DEZ, R_EZ, R_K};
      7'd18: u = '{U_ADD, R_VMZ, R_VZ, R_DEZ};
      7'd19: u = '{U_MUL, R_TZ, R_BZ, R_K};
      7'd20: u = '{U_MUL, R_TSQ, R_TX, R_TX};
      7'd21: u = '{U_MUL, R_T0, R_TY, R_TY};
      7'd22: u = '{U_ADD, R_TSQ, R_TSQ, R_T0};
      7'd23: u = '{U_MUL, R_T0, R_TZ, R_TZ};
      7'd24: u = '{U_ADD, R_TSQ, R_TSQ, R_T0};
      7'd25: u = '{U_FDIV, R_F, R_TSQ, R_ZERO};
      7'd26: u = '{U_MUL, R_SX, R_TX, R_F};
      7'd27: u = '{U_MUL, R_SY, R_TY, R_F};
      7'd28: u = '{U_MUL, R_SZ, R_TZ, R_F};
      // vp = vm + vm x t
      7'd29: u = '{U_MUL, R_T0, R_VMY, R_TZ};
      7'd30: u = '{U_MUL, R_T1, R_VMZ, R_TY};
      7'd31: u = '{U_SUB, R_T0, R_T0, R_T1};
      7'd32: u = '{U_ADD, R_VPX, R_VMX, R_T0};
      7'd33: u = '{U_MUL, R_T0, R_VMZ, R_TX};
      7'd34: u = '{U_MUL, R_T1, R_VMX, R_TZ};
      7'd35: u = '{U_SUB, R_T0, R_T0, R_T1};
      7'd36: u = '{U_ADD, R_VPY, R_VMY, R_T0};
      7'd37: u = '{U_MUL, R_T0, R_VMX, R_TY};
      7'd38: u = '{U_MUL, R_T1, R_VMY, R_TX};
      7'd39: u = '{U_SUB, R_T0, R_T0, R_T1};
      7'd40: u = '{U_ADD, R_VPZ, R_VMZ, R_T0};
      // v = vm + vp x s + dE
      7'd41: u = '{U_MUL, R_T0, R_VPY, R_SZ};
      7'd42: u = '{U_MUL, R_T1, R_VPZ, R_SY};
      7'd43: u = '{U_SUB, R_T0, R_T0, R_T1};
      7'd44: u = '{U_ADD, R_T0, R_VMX, R_T0};
      7'd45: u = '{U_ADD, R_VX, R_T0, R_DEX};
      7'd46: u = '{U_MUL, R_T0, R_VPZ, R_SX};
      7'd47: u = '{U_MUL, R_T1, R_VPX, R_SZ};
      7'd48: u = '{U_SUB, R_T0, R_T0, R_T1};
      7'd49: u = '{U_ADD, R_T0, R_VMY, R_T0};
      7'd50: u = '{U_ADD, R_VY, R_T0, R_DEY};
      7'd51: u = '{U_MUL, R_T0, R_VPX, R_SY};
      7'd52: u = '{U_MUL, R_T1, R_VPY, R_SX};
      7'd53: u = '{U_SUB, R_T0, R_T0, R_T1};
      7'd54: u = '{U_ADD, R_T0, R_VMZ, R_T0};
      7'd55: u = '{U_ADD, R_VZ, R_T0, R_DEZ};
      7'd56: u = '{U_MUL, R_T0, R_VX, R_DT};
      7'd57: u = '{U_ADD, R_PX, R_PX, R_T0};
      7'd58: u = '{U_MUL, R_T0, R_VY, R_DT};
      7'd59: u = '{U_ADD, R_PY, R_PY, R_T0};
      7'd60: u = '{U_MUL, R_T0, R_VZ, R_DT};
      7'd61: u = '{U_ADD, R_PZ, R_PZ, R_T0};
      default: u = '{U_ADD, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

  localparam logic [6:0] PC_LAST = 7'd61;

endpackage

FILE: rtl/core/boris_pusher_magnetic_bottle.sv
// ----------------------------------------------------------------------------
// boris_pusher_magnetic_bottle
// One particle advanced by Boris pushes in a magnetic bottle field.
// ----------------------------------------------------------------------------
// Load item: written into the particle state in S_LOAD, then passed out via S_OUT.
// Step item: 62 micro-ops; 60 run on one shared 32x32 multiply/add unit and the
// two restoring divides (q/m, rotation factor) on a DW-bit divider. No new item
// is accepted until the current one has left S_OUT for the output register.
// A finished item waits in the output register; the next item may start.
// Reset restores the register defaults and the initial particle state.
module boris_pusher_magnetic_bottle
  import bpmb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bpmb_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output bpmb_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [30:0] MASS_FLOOR = 31'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam int DW = 2 * FRAC_BITS + 34;   // divider numerator width
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_DIV = 5'b00100,
    S_OUT = 5'b01000, S_LOAD = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [6:0] pc_q;
  logic signed [31:0] rf_q [0:31];
  logic signed [31:0] rf_d;

  // finished state waits here so the next item can start
  bpmb_out_t out_q;
  logic      out_valid_q;
  logic      out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration
  logic [30:0] dt_q, mass_q, grad_q;
  logic signed [31:0] chg_q, ex_q, ey_q, ez_q, b0_q;
  logic wr_en;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 31'd655; chg_q <= 32'sd65536; mass_q <= 31'd65536;
      ex_q <= '0; ey_q <= '0; ez_q <= '0;
      b0_q <= 32'sd98304; grad_q <= 31'd1311;
    end else if (wr_en) begin
      unique case (ridx)
        REG_DT:   dt_q   <= pwdata[30:0];
        REG_CHG:  chg_q  <= pwdata;
        REG_MASS: mass_q <= pwdata[30:0];
        REG_EX:   ex_q   <= pwdata;
        REG_EY:   ey_q   <= pwdata;
        REG_EZ:   ez_q   <= pwdata;
        REG_B0:   b0_q   <= pwdata;
        REG_GRAD: grad_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_DT:   prdata = {1'b0, dt_q};
      REG_CHG:  prdata = chg_q;
      REG_MASS: prdata = {1'b0, mass_q};
      REG_EX:   prdata = ex_q;
      REG_EY:   prdata = ey_q;
      REG_EZ:   prdata = ez_q;
      REG_B0:   prdata = b0_q;
      REG_GRAD: prdata = {1'b0, grad_q};
      default:  prdata = '0;
    endcase
  end

  // operand fetch: config and constants are mapped into the slot space
  uinst_t ui;
  assign ui = prog(pc_q);

  logic [4:0] ia, ib, id;
  assign ia = 5'(ui.a);
  assign ib = 5'(ui.b);
  assign id = 5'(ui.dst);

  logic signed [31:0] opa, opb;
  always_comb begin
    case (ui.a)
      R_DT:   opa = {1'b0, dt_q};
      R_CHG:  opa = chg_q;
      R_EX:   opa = ex_q;
      R_EY:   opa = ey_q;
      R_EZ:   opa = ez_q;
      R_B0:   opa = b0_q;
      R_GRAD: opa = {1'b0, grad_q};
      R_ONE:  opa = FX_ONE;
      R_ZERO: opa = '0;
      default: opa = rf_q[ia];
    endcase
    case (ui.b)
      R_DT:   opb = {1'b0, dt_q};
      R_CHG:  opb = chg_q;
      R_EX:   opb = ex_q;
      R_EY:   opb = ey_q;
      R_EZ:   opb = ez_q;
      R_B0:   opb = b0_q;
      R_GRAD: opb = {1'b0, grad_q};
      R_ONE:  opb = FX_ONE;
      R_ZERO: opb = '0;
      default: opb = rf_q[ib];
    endcase
  end

  function automatic logic signed [31:0] sat(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // shared unit: saturating rounded 32x32 multiply (or negation), add or sub
  logic signed [63:0] prod;
  logic signed [65:0] rnd, sum;
  logic [5:0] sh;
  always_comb begin
    sh   = (ui.op == U_MULH) ? 6'(FRAC_BITS + 1) : 6'(FRAC_BITS);
    prod = opa * opb;
    rnd  = (66'(prod) + (66'sd1 <<< (sh - 6'd1))) >>> sh;
    sum  = (ui.op == U_SUB) ? 66'(opa) - 66'(opb) : 66'(opa) + 66'(opb);
    case (ui.op)
      U_MUL, U_MULH: rf_d = sat(rnd);
      U_NEGMUL:      rf_d = sat(-66'(sat(rnd)));
      default:       rf_d = sat(sum);
    endcase
  end

  // restoring divider, one bit per cycle
  logic [DW-1:0] dnum_q, dquo_q;
  logic [DW-1:0] drem_q, dden_q;
  logic [CW-1:0] dcnt_q;
  logic          dneg_q;
  logic [DW-1:0] rem_sh;
  assign rem_sh = {drem_q[DW-2:0], dnum_q[DW-1]};

  logic [DW-1:0] q_num, q_den, f_num, f_den;
  logic [30:0] meff;
  logic [31:0] cmag;
  always_comb begin
    meff  = (mass_q < MASS_FLOOR) ? MASS_FLOOR : mass_q;
    cmag  = chg_q[31] ? 32'(-chg_q) : 32'(chg_q);
    q_den = DW'(meff);
    q_num = (DW'(cmag) << FRAC_BITS) + DW'(meff >> 1);
    // tsq is a sum of squares, so 1 + tsq is positive
    f_den = DW'(unsigned'(64'(signed'(FX_ONE)) + 64'(opa)));
    f_num = (DW'(1) << (2 * FRAC_BITS + 1)) + (f_den >> 1);
  end

  logic [DW-1:0] dq_res;
  logic signed [65:0] qm_s;
  always_comb begin
    qm_s = dneg_q ? -$signed({1'b0, 65'(dquo_q)}) : $signed({1'b0, 65'(dquo_q)});
    if (ui.op == U_QDIV) dq_res = DW'(sat(qm_s));
    else dq_res = (dquo_q > DW'(32'h7fffffff)) ? DW'(32'h7fffffff) : dquo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) pc_q <= '0;
      else if (state_q == S_EXEC && ui.op != U_QDIV && ui.op != U_FDIV) pc_q <= pc_q + 7'd1;
      else if (state_q == S_DIV && dcnt_q == '0) pc_q <= pc_q + 7'd1;
      if (state_q == S_EXEC) dcnt_q <= CW'(DW);
      else if (state_q == S_DIV) dcnt_q <= dcnt_q - CW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i)
                state_d = (in_data_i.opcode == OP_LOAD) ? S_LOAD : S_EXEC;
      S_EXEC: if (ui.op == U_QDIV || ui.op == U_FDIV) state_d = S_DIV;
              else if (pc_q == PC_LAST) state_d = S_OUT;
      S_DIV:  if (dcnt_q == '0) state_d = S_EXEC;
      S_LOAD: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  bpmb_in_t ld_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) ld_q <= in_data_i;
    if (state_q == S_EXEC) begin
      dnum_q <= (ui.op == U_QDIV) ? q_num : f_num;
      dden_q <= (ui.op == U_QDIV) ? q_den : f_den;
      dneg_q <= chg_q[31];
      drem_q <= '0;
      dquo_q <= '0;
    end else if (state_q == S_DIV && dcnt_q != '0) begin
      dnum_q <= dnum_q << 1;
      if (rem_sh >= dden_q) begin
        drem_q <= rem_sh - dden_q;
        dquo_q <= {dquo_q[DW-2:0], 1'b1};
      end else begin
        drem_q <= rem_sh;
        dquo_q <= {dquo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
      rf_q[5'(R_PY)] <= FX_ONE;
      rf_q[5'(R_VX)] <= FX_ONE <<< 2;
      rf_q[5'(R_VZ)] <= FX_ONE * 3;
    end else if (state_q == S_LOAD) begin
      rf_q[5'(R_PX)] <= ld_q.new_pos_x; rf_q[5'(R_PY)] <= ld_q.new_pos_y;
      rf_q[5'(R_PZ)] <= ld_q.new_pos_z; rf_q[5'(R_VX)] <= ld_q.new_vel_x;
      rf_q[5'(R_VY)] <= ld_q.new_vel_y; rf_q[5'(R_VZ)] <= ld_q.new_vel_z;
    end else if (state_q == S_EXEC && ui.op != U_QDIV && ui.op != U_FDIV) begin
      rf_q[id] <= rf_d;
    end else if (state_q == S_DIV && dcnt_q == '0) begin
      rf_q[id] <= dq_res[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
      out_q       <= '{rf_q[5'(R_PX)], rf_q[5'(R_PY)], rf_q[5'(R_PZ)],
                       rf_q[5'(R_VX)], rf_q[5'(R_VY)], rf_q[5'(R_VZ)]};
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/bpmb_checker.sv
// ----------------------------------------------------------------------------
// bpmb_checker
// Port-level checks of the pusher's handshakes.
// ----------------------------------------------------------------------------
module bpmb_checker
  import bpmb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input bpmb_out_t out_data_o,
  input logic      pready
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after item accepted");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind boris_pusher_magnetic_bottle bpmb_checker u_bpmb_checker (.*);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Boris pusher testbench: APB register setup, random item traffic with idling
// and backpressure, and a bit-exact fixed-point prediction of each new state.
// ----------------------------------------------------------------------------
module tb_top
  import bpmb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC     = 16;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam longint ONE_FX   = 64'sd1 <<< FRAC;
  localparam longint M_FLOOR  = (ONE_FX + 50) / 100;
  localparam int     IDLE_MAX = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  bpmb_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  bpmb_out_t   out_data_o;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  boris_pusher_magnetic_bottle u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of registers and particle state
  longint dt_q, chg_q, mass_q, ex_q, ey_q, ez_q, b0_q, grad_q;
  longint pos[3], vel[3];

  bpmb_out_t state_q[$];
  int        fail_cnt = 0;
  bit        gaps_on = 1'b1;
  int        hold_cycles = 0;

  function automatic longint sat(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic longint rmul(longint a, longint b, int s);
    longint p;
    p = a * b + (64'sd1 <<< (s - 1));
    return sat(p >>> s);
  endfunction

  function automatic longint fm(longint a, longint b);
    return rmul(a, b, FRAC);
  endfunction

  function automatic void cross3(input longint u[3], input longint w[3],
                                 output longint r[3]);
    r[0] = sat(fm(u[1], w[2]) - fm(u[2], w[1]));
    r[1] = sat(fm(u[2], w[0]) - fm(u[0], w[2]));
    r[2] = sat(fm(u[0], w[1]) - fm(u[1], w[0]));
  endfunction

  function automatic void boris_push();
    longint e[3], b[3], t[3], sv[3], vm[3], vp[3], cr[3], de[3];
    longint m, mag, quo, qm, k, z2, ab, tsq, den, fq, f;
    e[0] = ex_q; e[1] = ey_q; e[2] = ez_q;
    m   = (mass_q < M_FLOOR) ? M_FLOOR : mass_q;
    mag = (chg_q < 0) ? -chg_q : chg_q;
    quo = ((mag <<< FRAC) + m / 2) / m;
    qm  = sat((chg_q < 0) ? -quo : quo);
    k   = rmul(qm, dt_q, FRAC + 1);
    z2  = fm(pos[2], pos[2]);
    ab  = fm(grad_q, b0_q);
    b[2] = fm(b0_q, sat(ONE_FX + fm(grad_q, z2)));
    b[0] = sat(-fm(fm(ab, pos[0]), pos[2]));
    b[1] = sat(-fm(fm(ab, pos[1]), pos[2]));
    for (int i = 0; i < 3; i++) begin
      de[i] = fm(e[i], k);
      vm[i] = sat(vel[i] + de[i]);
      t[i]  = fm(b[i], k);
    end
    tsq = sat(sat(fm(t[0], t[0]) + fm(t[1], t[1])) + fm(t[2], t[2]));
    den = ONE_FX + tsq;
    fq  = ((64'sd1 <<< (2 * FRAC + 1)) + den / 2) / den;
    f   = (fq > S32_MAX) ? S32_MAX : fq;
    for (int i = 0; i < 3; i++) sv[i] = fm(t[i], f);
    cross3(vm, t, cr);
    for (int i = 0; i < 3; i++) vp[i] = sat(vm[i] + cr[i]);
    cross3(vp, sv, cr);
    for (int i = 0; i < 3; i++) begin
      vel[i] = sat(sat(vm[i] + cr[i]) + de[i]);
      pos[i] = sat(pos[i] + fm(vel[i], dt_q));
    end
  endfunction

  function automatic bpmb_out_t next_state(bpmb_in_t it);
    bpmb_out_t r;
    if (it.opcode == OP_LOAD) begin
      pos[0] = it.new_pos_x; pos[1] = it.new_pos_y; pos[2] = it.new_pos_z;
      vel[0] = it.new_vel_x; vel[1] = it.new_vel_y; vel[2] = it.new_vel_z;
    end else begin
      boris_push();
    end
    r.out_pos_x = 32'(pos[0]); r.out_pos_y = 32'(pos[1]); r.out_pos_z = 32'(pos[2]);
    r.out_vel_x = 32'(vel[0]); r.out_vel_y = 32'(vel[1]); r.out_vel_z = 32'(vel[2]);
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(bpmb_in_t it);
    if (gaps_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    state_q.insert(state_q.size(), next_state(it));
  endtask

  task automatic step_item();
    bpmb_in_t it;
    it = '0;
    it.opcode    = OP_STEP;
    it.new_pos_x = $urandom; it.new_pos_y = $urandom; it.new_pos_z = $urandom;
    it.new_vel_x = $urandom; it.new_vel_y = $urandom; it.new_vel_z = $urandom;
    send_item(it);
  endtask

  task automatic load_item(longint px, longint py, longint pz,
                           longint vx, longint vy, longint vz);
    bpmb_in_t it;
    it.opcode = OP_LOAD;
    it.new_pos_x = 32'(px); it.new_pos_y = 32'(py); it.new_pos_z = 32'(pz);
    it.new_vel_x = 32'(vx); it.new_vel_y = 32'(vy); it.new_vel_z = 32'(vz);
    send_item(it);
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (state_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DT:   dt_q   = val[30:0];
      REG_CHG:  chg_q  = $signed(val);
      REG_MASS: mass_q = val[30:0];
      REG_EX:   ex_q   = $signed(val);
      REG_EY:   ey_q   = $signed(val);
      REG_EZ:   ez_q   = $signed(val);
      REG_B0:   b0_q   = $signed(val);
      REG_GRAD: grad_q = val[30:0];
      default: ;
    endcase
  endtask

  task automatic config_all(logic [31:0] dt, logic [31:0] chg, logic [31:0] m,
                            logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                            logic [31:0] b0, logic [31:0] grad);
    drain();
    reg_write(REG_DT, dt);     reg_write(REG_CHG, chg);
    reg_write(REG_MASS, m);    reg_write(REG_EX, ex);
    reg_write(REG_EY, ey);     reg_write(REG_EZ, ez);
    reg_write(REG_B0, b0);     reg_write(REG_GRAD, grad);
  endtask

  // ---------------- result checking ----------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    bpmb_out_t exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (state_q.size() == 0) begin
        $error("item out with nothing expected");
        fail_cnt++;
      end else begin
        exp_s = state_q.pop_front();
        check_field("out_pos_x", exp_s.out_pos_x, out_data_o.out_pos_x);
        check_field("out_pos_y", exp_s.out_pos_y, out_data_o.out_pos_y);
        check_field("out_pos_z", exp_s.out_pos_z, out_data_o.out_pos_z);
        check_field("out_vel_x", exp_s.out_vel_x, out_data_o.out_vel_x);
        check_field("out_vel_y", exp_s.out_vel_y, out_data_o.out_vel_y);
        check_field("out_vel_z", exp_s.out_vel_z, out_data_o.out_vel_z);
      end
    end
  end

  // receiver stall, with a long hold counted down here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(99) < 25);
    end
  end

  // watchdog: cycles without any accepted item on either side
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_MAX) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_state();
    repeat (4) step_item();
  endtask

  task automatic test_load_extremes();
    load_item(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    step_item();
    load_item(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX);
    step_item();
    load_item(0, 0, 0, 0, 0, 0);
    step_item();
    load_item(-1, -1, -1, -1, -1, -1);
    step_item();
  endtask

  task automatic test_mass_floor();
    config_all(655, 32'h0001_0000, 0, 32'h0000_8000, 0, 32'hFFFF_8000,
               98304, 1311);
    load_item(0, ONE_FX, ONE_FX, 4 * ONE_FX, 0, 3 * ONE_FX);
    step_item(); step_item();
    config_all(655, 32'hFFFF_0000, 1, 0, 0, 0, 98304, 1311);
    step_item();
    config_all(655, 32'h0001_0000, 654, 0, 0, 0, 98304, 1311);
    step_item();
  endtask

  task automatic test_config_extremes();
    config_all(32'h7FFF_FFFF, 32'h8000_0000, 655, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_item(ONE_FX, -ONE_FX, 2 * ONE_FX, ONE_FX, ONE_FX, ONE_FX);
    step_item(); step_item();
    config_all(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0);
    step_item(); step_item();
    config_all(1, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0,
               32'hFFFF_FFFF, 1);
    step_item(); step_item();
  endtask

  task automatic test_random_flight();
    logic [31:0] dt, chg, m, b0;
    for (int ph = 0; ph < 8; ph++) begin
      dt  = (ph == 7) ? $urandom & 32'h7FFF_FFFF : $urandom_range(4000, 1);
      chg = (ph == 6) ? $urandom : $signed($urandom_range(262144)) - 131072;
      m   = (ph == 5) ? $urandom_range(700) : $urandom_range(300000, 655);
      b0  = (ph == 4) ? $urandom : $signed($urandom_range(400000)) - 200000;
      config_all(dt, chg, m,
                 $signed($urandom_range(131072)) - 65536,
                 $signed($urandom_range(131072)) - 65536,
                 (ph == 3) ? $urandom : $signed($urandom_range(131072)) - 65536,
                 b0, (ph == 2) ? $urandom : $urandom_range(20000));
      gaps_on = (ph != 1);
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(99) < 5)
          load_item($signed($urandom), $signed($urandom), $signed($urandom),
                    $signed($urandom), $signed($urandom), $signed($urandom));
        else if ($urandom_range(99) < 8)
          load_item($signed($urandom_range(20 * 65536)) - 10 * 65536,
                    $signed($urandom_range(20 * 65536)) - 10 * 65536,
                    $signed($urandom_range(20 * 65536)) - 10 * 65536,
                    $signed($urandom_range(16 * 65536)) - 8 * 65536,
                    $signed($urandom_range(16 * 65536)) - 8 * 65536,
                    $signed($urandom_range(16 * 65536)) - 8 * 65536);
        else
          step_item();
      end
      gaps_on = 1'b1;
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 1500;
    for (int n = 0; n < 12; n++) step_item();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    dt_q = 655; chg_q = 65536; mass_q = 65536;
    ex_q = 0; ey_q = 0; ez_q = 0; b0_q = 98304; grad_q = 1311;
    pos[0] = 0; pos[1] = ONE_FX; pos[2] = 0;
    vel[0] = 4 * ONE_FX; vel[1] = 0; vel[2] = 3 * ONE_FX;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_load_extremes();
    test_mass_floor();
    test_config_extremes();
    test_backpressure();
    test_random_flight();

    drain();
    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0 && state_q.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
